// ===== src/sem_pkg.sv =====
package sem_pkg;
   localparam int DefMaxWidth  = 2048;
   localparam int DefMaxHeight = 4096;
   localparam logic [0:0] CsrWidth  = 1'b0;
   localparam logic [0:0] CsrHeight = 1'b1;
   localparam logic OpPixel = 1'b0;
   localparam logic OpDrain = 1'b1;

   typedef struct packed {
      logic        valid;
      logic        last;
      logic [71:0] top;
      logic [71:0] mid;
      logic [71:0] bot;
   } sem_job_type;

   typedef enum logic [1:0] {
      BkIdle,
      BkRoot,
      BkHold
   } sem_back_state_type;

   function automatic logic [21:0] sem_sumsq(input logic [7:0] p00, input logic [7:0] p01,
                                             input logic [7:0] p02, input logic [7:0] p10,
                                             input logic [7:0] p12, input logic [7:0] p20,
                                             input logic [7:0] p21, input logic [7:0] p22);
      logic signed [21:0] gx;
      logic signed [21:0] gy;
      gx = $signed({4'd0, p02}) - $signed({4'd0, p00})
         + $signed({3'd0, p12, 1'b0}) - $signed({3'd0, p10, 1'b0})
         + $signed({4'd0, p22}) - $signed({4'd0, p20});
      gy = $signed({4'd0, p20}) - $signed({4'd0, p00})
         + $signed({3'd0, p21, 1'b0}) - $signed({3'd0, p01, 1'b0})
         + $signed({4'd0, p22}) - $signed({4'd0, p02});
      return 22'(gx * gx + gy * gy);
   endfunction
endpackage

// ===== src/sem_front.sv =====
module sem_front import sem_pkg::*; #(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic        opcode,
   input  logic [23:0] pix,
   input  logic [11:0] cfg_w,
   input  logic [12:0] cfg_h,
   output logic        ready,
   output sem_job_type job
);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT + 2) + 1;
   localparam int SA = (CW + 1 > RW) ? CW + 1 : RW;
   localparam int SW = (SA > 14) ? SA : 14;

   logic [23:0] mem_lo [MAX_WIDTH];
   logic [23:0] mem_hi [MAX_WIDTH];
   logic [23:0] win_ff [3][3];
   logic [23:0] top_ff, mid_ff;
   logic fetched_ff;
   sem_job_type job_ff;
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [SW-1:0] w, h, cc, cr;
   logic [23:0] px, top, mid;
   logic [23:0] nb [3][3];
   logic valid, last;

   assign ready = fetched_ff;
   assign job = job_ff;

   always_comb begin
      w = (cfg_w == 0) ? SW'(1) : (SW'(cfg_w) > SW'(MAX_WIDTH) ? SW'(MAX_WIDTH) : SW'(cfg_w));
      h = (cfg_h == 0) ? SW'(1) :
          (SW'(cfg_h) > SW'(MAX_HEIGHT) ? SW'(MAX_HEIGHT) : SW'(cfg_h));
      px = (opcode == OpPixel && SW'(row_ff) < h) ? pix : '0;
      top = top_ff;
      mid = mid_ff;
      cc = '0; cr = '0;
      if (col_ff == 0) begin
         valid = row_ff >= 2;
         cr = SW'(row_ff) - SW'(2); cc = w - SW'(1);
         for (int i = 0; i < 3; i++) begin
            nb[i][0] = win_ff[i][1]; nb[i][1] = win_ff[i][2]; nb[i][2] = '0;
         end
      end else begin
         valid = row_ff >= 1;
         cr = SW'(row_ff) - SW'(1); cc = SW'(col_ff) - SW'(1);
         for (int i = 0; i < 3; i++) begin
            nb[i][0] = win_ff[i][1]; nb[i][1] = win_ff[i][2];
         end
         nb[0][2] = top; nb[1][2] = mid; nb[2][2] = px;
      end
      valid = valid && cr < h && cc < w;
      if (cc == 0) for (int i = 0; i < 3; i++) nb[i][0] = '0;
      if (cc + 1 >= w) for (int i = 0; i < 3; i++) nb[i][2] = '0;
      if (cr == 0) for (int i = 0; i < 3; i++) nb[0][i] = '0;
      if (cr + 1 >= h) for (int i = 0; i < 3; i++) nb[2][i] = '0;
      last = valid && cr == h - 1 && cc == w - 1;
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mem_hi[col_ff] <= mid;
         mem_lo[col_ff] <= px;
      end
      top_ff <= mem_hi[col_ff];
      mid_ff <= mem_lo[col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0;
         for (int i = 0; i < 3; i++) for (int j = 0; j < 3; j++) win_ff[i][j] <= '0;
         job_ff.valid <= 1'b0;
         fetched_ff <= 1'b0;
      end else begin
         job_ff.valid <= take && valid;
         fetched_ff <= !take;
         if (take) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1]; win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= top; win_ff[1][2] <= mid; win_ff[2][2] <= px;
            if (last) begin
               col_ff <= '0; row_ff <= '0;
            end else if (SW'(col_ff) + SW'(1) >= w) begin
               col_ff <= '0;
               if (SW'(row_ff) + SW'(1) > h + SW'(1)) row_ff <= '0;
               else row_ff <= row_ff + RW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
               if (SW'(row_ff) > h + SW'(1)) begin
                  row_ff <= '0; col_ff <= '0;
               end
            end
         end
      end
      job_ff.last <= last;
      job_ff.top <= {nb[0][0], nb[0][1], nb[0][2]};
      job_ff.mid <= {nb[1][0], nb[1][1], nb[1][2]};
      job_ff.bot <= {nb[2][0], nb[2][1], nb[2][2]};
   end
endmodule

// ===== src/sem_back.sv =====
module sem_back import sem_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  sem_job_type job,
   input  logic        rsp_ready,
   output logic        rsp_valid,
   output logic [7:0]  red_out,
   output logic [7:0]  green_out,
   output logic [7:0]  blue_out,
   output logic        frame_end,
   output logic        room
);
   // Two-entry queue ahead of a root finder that resolves one bit per cycle.
   sem_job_type q_ff [2];
   logic [1:0] cnt_ff;
   logic load;
   sem_back_state_type state_ff, state_in;
   logic [21:0] s_ff [3];
   logic [7:0] n_ff [3];
   logic [7:0] t [3];
   logic [2:0] bit_ff;
   logic last_ff;

   assign room = cnt_ff != 2'd2;
   assign red_out = n_ff[2];
   assign green_out = n_ff[1];
   assign blue_out = n_ff[0];
   assign frame_end = last_ff;

   always_comb begin
      state_in = state_ff;
      load = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         BkIdle: begin
            if (cnt_ff != 2'd0) begin
               load = 1'b1;
               state_in = BkRoot;
            end
         end
         BkRoot: begin
            if (bit_ff == 3'd0) state_in = BkHold;
         end
         BkHold: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = BkIdle;
         end
         default: state_in = BkIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= BkIdle;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_ff + 2'(job.valid) - 2'(load);
   end

   always_ff @(posedge clock) begin
      if (job.valid && (cnt_ff == 2'd0 || (cnt_ff == 2'd1 && load))) q_ff[0] <= job;
      else if (load) q_ff[0] <= q_ff[1];
      if (job.valid && !(cnt_ff == 2'd0 || (cnt_ff == 2'd1 && load))) q_ff[1] <= job;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) t[k] = n_ff[k] | (8'd1 << bit_ff);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int k = 0; k < 3; k++) begin
            s_ff[k] <= sem_sumsq(q_ff[0].top[48+8*k +: 8], q_ff[0].top[24+8*k +: 8],
                                 q_ff[0].top[8*k +: 8], q_ff[0].mid[48+8*k +: 8],
                                 q_ff[0].mid[8*k +: 8], q_ff[0].bot[48+8*k +: 8],
                                 q_ff[0].bot[24+8*k +: 8], q_ff[0].bot[8*k +: 8]);
            n_ff[k] <= '0;
         end
         bit_ff <= 3'd7;
         last_ff <= q_ff[0].last;
      end else if (state_ff == BkRoot) begin
         for (int k = 0; k < 3; k++) begin
            if (22'(t[k]) * 22'(t[k]) - 22'(t[k]) < s_ff[k]) n_ff[k] <= t[k];
         end
         bit_ff <= bit_ff - 3'd1;
      end
   end
endmodule

// ===== src/sobel_edge_magnitude_rgb.sv =====
// Sobel edge magnitude on an RGB raster stream, each color handled alone.
// Channels: req_ carries one pixel or drain tick per transfer; rsp_ returns
// at most one result per transfer; csr_ writes image width (index 0) or
// height (index 1); the user writes only while the block is idle, and the
// block does not enforce it. The result for a pixel is due one row and one
// pixel after it enters; after the last pixel, width plus one drain ticks
// flush the rest. The front reads both line stores into registers and
// accepts only after that read, so request transfers never come back to
// back. The back takes a job from its two-entry queue, squares in that
// cycle and then finds the root one bit per cycle. A released result passes
// the job register, the queue, the square and the root steps and is then
// offered until rsp_ready; the next job starts once the last result leaves.
// When rsp_ready stays low the back holds its result, the queue fills and
// req_ready drops until room frees. Reset clears counters, window, queue and
// the back and sets 640 by 480; line store contents stay undefined but are
// never used before being written.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
   parameter int MAX_WIDTH  = DefMaxWidth,
   parameter int MAX_HEIGHT = DefMaxHeight
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [7:0]  req_red_in,
   input  logic [7:0]  req_green_in,
   input  logic [7:0]  req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red_out,
   output logic [7:0]  rsp_green_out,
   output logic [7:0]  rsp_blue_out,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data
);
   logic [11:0] w_ff;
   logic [12:0] h_ff;
   sem_job_type job;
   logic take, room, front_ready;

   assign csr_ready = 1'b1;
   // A transfer needs fresh line store data and a free queue slot.
   assign req_ready = front_ready && room;
   assign take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= 12'd640; h_ff <= 13'd480;
      end else if (csr_valid) begin
         if (csr_index == CsrWidth) w_ff <= csr_data[11:0];
         else if (csr_index == CsrHeight) h_ff <= csr_data;
      end
   end

   sem_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
      .clock, .reset, .take, .opcode(req_opcode),
      .pix({req_red_in, req_green_in, req_blue_in}),
      .cfg_w(w_ff), .cfg_h(h_ff), .ready(front_ready), .job
   );

   sem_back u_back (
      .clock, .reset, .job, .rsp_ready, .rsp_valid,
      .red_out(rsp_red_out), .green_out(rsp_green_out), .blue_out(rsp_blue_out),
      .frame_end(rsp_frame_end), .room
   );

   a_job_after_take: assert property (@(posedge clock) disable iff (reset)
      job.valid |-> $past(take)) else $error("job without transfer");
   a_take_spaced: assert property (@(posedge clock) disable iff (reset)
      take |=> !take) else $error("transfers too close");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
      && $stable({rsp_red_out, rsp_green_out, rsp_blue_out, rsp_frame_end}))
      else $error("result changed while stalled");
endmodule
